>>> rtl/segment_partition_split_macros.svh
// Assertion macros for the segment/partition split block.
// Used by the port checker; no other dependencies.
`ifndef SEGMENT_PARTITION_SPLIT_MACROS_SVH
`define SEGMENT_PARTITION_SPLIT_MACROS_SVH
// Check an implication every clock, quiet during reset.
`define SPS_ASSERT_IMPL(label, clk, rstn, cond, concl) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (concl)) \
        else $error("segment_partition_split check failed");
// Check a next-cycle implication, quiet during reset.
`define SPS_ASSERT_NEXT(label, clk, rstn, cond, concl) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (concl)) \
        else $error("segment_partition_split check failed");
`endif

>>> rtl/sps_pkg.sv
// Shared types and constants for the segment/partition split block.
// No dependencies.
`default_nettype none
package sps_pkg;
    localparam int COORD_BITS = 16;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int CROSS_BITS = 2 * DIFF_BITS + 1;
    localparam int MAG_BITS   = CROSS_BITS + 1;
    localparam int DIV_STEPS  = COORD_BITS + 2;
    localparam int DIN_BITS   = 8 * COORD_BITS;
    localparam int DOUT_BITS  = ((2 + 2 * COORD_BITS + 2 + 7) / 8) * 8;

    localparam logic [1:0] CLS_FRONT = 2'd0;
    localparam logic [1:0] CLS_BACK  = 2'd1;
    localparam logic [1:0] CLS_SPLIT = 2'd2;

    typedef struct packed {
        logic [MAG_BITS-1:0]   a;
        logic [MAG_BITS-1:0]   c;
        logic [DIFF_BITS-1:0]  b;
        logic                  neg;
        logic                  zero;
    } div_req_t;
endpackage
`default_nettype wire

>>> rtl/sps_divider.sv
// Pipelined rounding divider: round(a*b/c), one bit of b per stage.
// Depends on sps_pkg.
`default_nettype none
module sps_divider (
    input  wire logic                              aclk,
    input  wire logic                              adv,
    input  wire sps_pkg::div_req_t                 req,
    output logic signed [sps_pkg::DIFF_BITS:0]     quot,
    output logic                                   inexact
);
    localparam int N = sps_pkg::DIV_STEPS;
    localparam int MB = sps_pkg::MAG_BITS;
    localparam int QB = sps_pkg::DIFF_BITS + 1;

    sps_pkg::div_req_t  rq_reg [N+1];
    logic [MB:0]        r_reg  [N+1];
    logic [QB-1:0]      q_reg  [N+1];
    logic [MB:0]        r_next [N];
    logic [QB-1:0]      q_next [N];

    // Each stage: shift, trim the remainder, then add a when this bit of b is set.
    always_comb begin
        logic [MB:0]   r1;
        logic [QB-1:0] q1;
        logic [N-1:0]  bits;
        for (int g = 0; g < N; g++) begin
            bits = N'(rq_reg[g].b);
            r1 = r_reg[g] << 1;
            q1 = q_reg[g] << 1;
            if (r1 >= {1'b0, rq_reg[g].c}) begin
                r1 = r1 - {1'b0, rq_reg[g].c};
                q1 = q1 + 1'b1;
            end
            r_next[g] = r1;
            q_next[g] = q1;
            if (bits[N-1-g]) begin
                r_next[g] = r1 + {1'b0, rq_reg[g].a};
                if (r_next[g] >= {1'b0, rq_reg[g].c}) begin
                    r_next[g] = r_next[g] - {1'b0, rq_reg[g].c};
                    q_next[g] = q1 + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rq_reg[0] <= req;
            r_reg[0]  <= '0;
            q_reg[0]  <= '0;
            for (int i = 0; i < N; i++) begin
                rq_reg[i+1] <= rq_reg[i];
                r_reg[i+1]  <= r_next[i];
                q_reg[i+1]  <= q_next[i];
            end
        end
    end

    logic [QB-1:0] qr;
    always_comb begin
        qr = q_reg[N];
        if (r_reg[N] != '0 && ({r_reg[N], 1'b0} >= {2'b0, rq_reg[N].c}))
            qr = qr + 1'b1;
        inexact = (r_reg[N] != '0);
        // Quotient stays below 2^(QB-1), so its top bit is clear.
        if (rq_reg[N].zero)
            quot = '0;
        else if (rq_reg[N].neg)
            quot = -$signed(qr);
        else
            quot = $signed(qr);
    end
endmodule
`default_nettype wire

>>> rtl/segment_partition_split.sv
// Segment vs partition line classifier with rounded crossing point.
// Pipeline: DIV_STEPS + 4 register stages (22 at 16-bit coordinates). Throughput
// one transaction per cycle when no result is waiting; every stage advances together.
// A waiting result freezes the whole pipe and drops s_tready until it is taken.
// Reset (aresetn low, synchronous) clears the valids; data registers are not reset.
`default_nettype none
module segment_partition_split (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // part_x1, part_y1, part_x2, part_y2, seg_x1, seg_y1, seg_x2, seg_y2 (low up)
    input  wire logic [sps_pkg::DIN_BITS-1:0]  s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // side_code, split_x, split_y, split_exact, head_in_front (low up), zero fill
    output logic [sps_pkg::DOUT_BITS-1:0]      m_tdata
);
    localparam int CB = sps_pkg::COORD_BITS;
    localparam int DB = sps_pkg::DIFF_BITS;
    localparam int XB = sps_pkg::CROSS_BITS;
    localparam int MB = sps_pkg::MAG_BITS;
    localparam int OB = sps_pkg::DOUT_BITS;
    localparam int LAT = sps_pkg::DIV_STEPS + 3;

    // Whole pipe advances when the output slot is free or being emptied.
    logic adv;
    assign adv = !m_tvalid || m_tready;
    assign s_tready = adv;

    logic [LAT-1:0] vld_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            m_tvalid <= 1'b0;
        end else if (adv) begin
            vld_reg  <= {vld_reg[LAT-2:0], s_tvalid};
            m_tvalid <= vld_reg[LAT-1];
        end
    end

    // Stage 1: differences.
    logic signed [CB-1:0] px1, py1, px2, py2, ax, ay, bx, by;
    assign {by, bx, ay, ax, py2, px2, py1, px1} = s_tdata;
    logic signed [DB-1:0] pdx_reg, pdy_reg, dx_reg, dy_reg;
    logic signed [DB-1:0] ax1_reg, ay1_reg, bx1_reg, by1_reg;
    logic signed [CB-1:0] ax_s1_reg, ay_s1_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            pdx_reg <= DB'(px2) - DB'(px1);
            pdy_reg <= DB'(py2) - DB'(py1);
            dx_reg  <= DB'(bx) - DB'(ax);
            dy_reg  <= DB'(by) - DB'(ay);
            ax1_reg <= DB'(ax) - DB'(px1);
            ay1_reg <= DB'(ay) - DB'(py1);
            bx1_reg <= DB'(bx) - DB'(px1);
            by1_reg <= DB'(by) - DB'(py1);
            ax_s1_reg <= ax;
            ay_s1_reg <= ay;
        end
    end

    // Stage 2: products.
    logic signed [2*DB-1:0] m0_reg, m1_reg, m2_reg, m3_reg, m4_reg, m5_reg;
    logic signed [DB-1:0] dx2_reg, dy2_reg;
    logic signed [CB-1:0] ax_s2_reg, ay_s2_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            m0_reg <= pdy_reg * ax1_reg;
            m1_reg <= pdx_reg * ay1_reg;
            m2_reg <= pdy_reg * bx1_reg;
            m3_reg <= pdx_reg * by1_reg;
            m4_reg <= dx_reg * pdx_reg;
            m5_reg <= dy_reg * pdy_reg;
            dx2_reg <= dx_reg;
            dy2_reg <= dy_reg;
            ax_s2_reg <= ax_s1_reg;
            ay_s2_reg <= ay_s1_reg;
        end
    end

    // Stage 3: cross products, dot, classification.
    logic signed [XB-1:0] ca, cb, dot;
    logic signed [XB:0] den;
    assign ca  = XB'(m0_reg) - XB'(m1_reg);
    assign cb  = XB'(m2_reg) - XB'(m3_reg);
    assign dot = XB'(m4_reg) + XB'(m5_reg);
    assign den = (XB+1)'(cb) - (XB+1)'(ca);

    logic [1:0] side;
    always_comb begin
        if (ca == 0 && cb == 0)
            side = dot[XB-1] ? sps_pkg::CLS_BACK : sps_pkg::CLS_FRONT;
        else if (!ca[XB-1] && !cb[XB-1])
            side = sps_pkg::CLS_FRONT;
        else if (ca <= 0 && cb <= 0)
            side = sps_pkg::CLS_BACK;
        else
            side = sps_pkg::CLS_SPLIT;
    end

    logic [MB-1:0] amag, cmag;
    assign amag = ca[XB-1] ? MB'(-(MB)'(ca)) : MB'(ca);
    assign cmag = den[XB] ? MB'(-den) : MB'(den);

    sps_pkg::div_req_t rx, ry;
    always_comb begin
        rx.a = amag;
        rx.c = cmag;
        rx.b = dx2_reg[DB-1] ? DB'(-dx2_reg) : dx2_reg;
        rx.neg = (ca[XB-1] ^ dx2_reg[DB-1]) ^ den[XB];
        rx.zero = (ca == 0) || (dx2_reg == 0);
        ry = rx;
        ry.b = dy2_reg[DB-1] ? DB'(-dy2_reg) : dy2_reg;
        ry.neg = (ca[XB-1] ^ dy2_reg[DB-1]) ^ den[XB];
        ry.zero = (ca == 0) || (dy2_reg == 0);
    end

    // Side-band travels beside the divider.
    localparam int DL = sps_pkg::DIV_STEPS + 1;
    logic [1:0]           side_d_reg [DL];
    logic                 hf_d_reg   [DL];
    logic signed [CB-1:0] ax_d_reg   [DL];
    logic signed [CB-1:0] ay_d_reg   [DL];
    always_ff @(posedge aclk) begin
        if (adv) begin
            side_d_reg[0] <= side;
            hf_d_reg[0]   <= !ca[XB-1] && (ca != 0);
            ax_d_reg[0]   <= ax_s2_reg;
            ay_d_reg[0]   <= ay_s2_reg;
            for (int i = 1; i < DL; i++) begin
                side_d_reg[i] <= side_d_reg[i-1];
                hf_d_reg[i]   <= hf_d_reg[i-1];
                ax_d_reg[i]   <= ax_d_reg[i-1];
                ay_d_reg[i]   <= ay_d_reg[i-1];
            end
        end
    end

    logic signed [DB:0] qx, qy;
    logic inx, iny;
    sps_divider u_div_x (.aclk(aclk), .adv(adv), .req(rx), .quot(qx), .inexact(inx));
    sps_divider u_div_y (.aclk(aclk), .adv(adv), .req(ry), .quot(qy), .inexact(iny));

    // Output register; zero the crossing fields unless the segment is split.
    logic split;
    logic [CB-1:0] sx, sy;
    assign split = (side_d_reg[DL-1] == sps_pkg::CLS_SPLIT);
    assign sx = CB'((DB+1)'(ax_d_reg[DL-1]) - qx);
    assign sy = CB'((DB+1)'(ay_d_reg[DL-1]) - qy);
    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata <= OB'({split && hf_d_reg[DL-1],
                            split && !inx && !iny,
                            split ? sy : CB'(0),
                            split ? sx : CB'(0),
                            side_d_reg[DL-1]});
        end
    end
endmodule
`default_nettype wire

>>> rtl/sps_checker.sv
// Port checker for segment_partition_split, bound to the top level.
// Depends on sps_pkg and segment_partition_split_macros.svh.
`default_nettype none
`include "segment_partition_split_macros.svh"
module sps_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [sps_pkg::DOUT_BITS-1:0] m_tdata
);
    logic [1:0]                      side_code;
    logic                            is_split;
    logic [sps_pkg::DOUT_BITS-3:0]   payload;
    assign side_code = m_tdata[1:0];
    assign is_split  = (side_code == sps_pkg::CLS_SPLIT);
    assign payload   = m_tdata[sps_pkg::DOUT_BITS-1:2];

    `SPS_ASSERT_IMPL(a_side_legal, aclk, aresetn, m_tvalid, side_code <= sps_pkg::CLS_SPLIT)
    `SPS_ASSERT_IMPL(a_nosplit_zero, aclk, aresetn, m_tvalid && !is_split, payload == '0)
    `SPS_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `SPS_ASSERT_IMPL(a_ready, aclk, aresetn, !m_tvalid, s_tready)
endmodule
bind segment_partition_split sps_checker u_chk (.*);
`default_nettype wire

>>> tb/segment_partition_split_test.sv
// Self-checking testbench for segment_partition_split: directed and random
// segment/partition pairs, scoreboarded against an in-bench predictor.
// Depends on sps_pkg and the segment_partition_split RTL.
`timescale 1ns / 100ps
`default_nettype none

// Input transaction fields, highest bits first in s_tdata.
typedef struct packed {
    logic signed [15:0] sy2;
    logic signed [15:0] sx2;
    logic signed [15:0] sy1;
    logic signed [15:0] sx1;
    logic signed [15:0] py2;
    logic signed [15:0] px2;
    logic signed [15:0] py1;
    logic signed [15:0] px1;
} seg_pair_t;

// Classification result, unpacked from m_tdata.
typedef struct {
    logic [1:0]         side;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic               exact;
    logic               head_front;
} split_result_t;

class split_scoreboard;
    split_result_t pending[$];
    int            errors;

    function new();
        errors = 0;
    endfunction

    // Rounded num*d/den, halves away from zero; clears exact on a remainder.
    static function longint round_ratio(longint num, longint d, longint den,
                                        ref bit exact);
        longint p, ap, aden, q, r;
        p    = num * d;
        ap   = (p < 0) ? -p : p;
        aden = (den < 0) ? -den : den;
        q    = ap / aden;
        r    = ap % aden;
        if (r != 0) begin
            exact = 0;
            if (2 * r >= aden) q++;
        end
        return ((p < 0) != (den < 0)) ? -q : q;
    endfunction

    static function split_result_t classify(seg_pair_t t);
        split_result_t res;
        longint pdx, pdy, dx, dy, ca, cb, den, qx, qy;
        bit exact;
        res = '{sps_pkg::CLS_FRONT, 0, 0, 0, 0};
        pdx = longint'(t.px2) - t.px1;
        pdy = longint'(t.py2) - t.py1;
        dx  = longint'(t.sx2) - t.sx1;
        dy  = longint'(t.sy2) - t.sy1;
        ca  = pdy * (t.sx1 - longint'(t.px1)) - pdx * (t.sy1 - longint'(t.py1));
        cb  = pdy * (t.sx2 - longint'(t.px1)) - pdx * (t.sy2 - longint'(t.py1));
        if (ca == 0 && cb == 0) begin
            res.side = (dx * pdx + dy * pdy >= 0) ? sps_pkg::CLS_FRONT
                                                  : sps_pkg::CLS_BACK;
        end else if (ca >= 0 && cb >= 0) begin
            res.side = sps_pkg::CLS_FRONT;
        end else if (ca <= 0 && cb <= 0) begin
            res.side = sps_pkg::CLS_BACK;
        end else begin
            den   = cb - ca;
            exact = 1;
            qx    = round_ratio(ca, dx, den, exact);
            qy    = round_ratio(ca, dy, den, exact);
            res.side       = sps_pkg::CLS_SPLIT;
            res.sx         = 16'(t.sx1 - qx);
            res.sy         = 16'(t.sy1 - qy);
            res.exact      = exact;
            res.head_front = (ca > 0);
        end
        return res;
    endfunction

    function void note_input(seg_pair_t t);
        pending.push_back(classify(t));
    endfunction

    function void check_result(logic [sps_pkg::DOUT_BITS-1:0] d);
        split_result_t got, want;
        got.side       = d[1:0];
        got.sx         = d[17:2];
        got.sy         = d[33:18];
        got.exact      = d[34];
        got.head_front = d[35];
        if (pending.size() == 0) begin
            $error("unexpected result transaction, data %h", d);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.side !== want.side) begin
            $error("side_code: expected %0d actual %0d", want.side, got.side);
            errors++;
        end
        if (got.sx !== want.sx) begin
            $error("split_x: expected %0d actual %0d", want.sx, got.sx);
            errors++;
        end
        if (got.sy !== want.sy) begin
            $error("split_y: expected %0d actual %0d", want.sy, got.sy);
            errors++;
        end
        if (got.exact !== want.exact) begin
            $error("split_exact: expected %0d actual %0d", want.exact, got.exact);
            errors++;
        end
        if (got.head_front !== want.head_front) begin
            $error("head_in_front: expected %0d actual %0d",
                   want.head_front, got.head_front);
            errors++;
        end
    endfunction
endclass

module segment_partition_split_test;
    localparam int WATCHDOG_CYCLES = 20000;
    localparam int DRAIN_CYCLES    = 60;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [sps_pkg::DIN_BITS-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [sps_pkg::DOUT_BITS-1:0] m_tdata;

    // Idle rates in percent; the receiver's long hold-off overrides the receive rate.
    int  send_idle_pct = 12;
    int  recv_idle_pct = 68;
    bit  recv_hold = 0;
    int  stall_count = 0;
    bit  sim_done = 0;

    split_scoreboard sb = new();

    segment_partition_split dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #5 aclk = ~aclk;

    // Receiver: randomly withhold ready; hold it low during the backpressure burst.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 0;
        end else begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: count cycles without any transaction on either channel.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn || sim_done)
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= WATCHDOG_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Offer one transaction; keep valid high across back-to-back items.
    task automatic send_item(seg_pair_t t);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= t;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(t);
    endtask

    function automatic logic signed [15:0] rand_coord(int mode);
        case (mode)
            0:       return 16'($urandom);
            1:       return 16'($signed($urandom_range(64)) - 32);
            2:       return $urandom_range(1) ? 16'sh7fff - 16'($urandom_range(3))
                                              : 16'sh8000 + 16'($urandom_range(3));
            default: return 16'($signed($urandom_range(2000)) - 1000);
        endcase
    endfunction

    // Random pairs: mostly free endpoints, with some collinear and reflected segments.
    function automatic seg_pair_t rand_pair();
        seg_pair_t t;
        int m;
        m = $urandom_range(3);
        t.px1 = rand_coord(m); t.py1 = rand_coord(m);
        t.px2 = rand_coord(m); t.py2 = rand_coord(m);
        t.sx1 = rand_coord(m); t.sy1 = rand_coord(m);
        case ($urandom_range(9))
            0: begin
                // Collinear with the partition, either direction.
                t.sx1 = t.px1; t.sy1 = t.py1;
                t.sx2 = $urandom_range(1) ? t.px2 : 16'(2 * t.px1 - t.px2);
                t.sy2 = (t.sx2 == t.px2) ? t.py2 : 16'(2 * t.py1 - t.py2);
            end
            1: begin
                // Reflect the start across the partition start.
                t.sx2 = 16'(2 * t.px1 - t.sx1 + $signed($urandom_range(4)) - 2);
                t.sy2 = 16'(2 * t.py1 - t.sy1 + $signed($urandom_range(4)) - 2);
            end
            default: begin
                t.sx2 = rand_coord(m); t.sy2 = rand_coord(m);
            end
        endcase
        return t;
    endfunction

    function automatic seg_pair_t mk(int a, int b, int c, int d,
                                     int e, int f, int g, int h);
        seg_pair_t t;
        t.px1 = 16'(a); t.py1 = 16'(b); t.px2 = 16'(c); t.py2 = 16'(d);
        t.sx1 = 16'(e); t.sy1 = 16'(f); t.sx2 = 16'(g); t.sy2 = 16'(h);
        return t;
    endfunction

    task automatic run_phase(int n);
        repeat (n) send_item(rand_pair());
    endtask

    task automatic wait_empty();
        s_tvalid <= 0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: front, back, collinear both ways, degenerate line,
        // exact and rounded splits, half rounding, extreme coordinates.
        send_item(mk(0, 0, 10, 0, 0, 5, 10, 5));
        send_item(mk(0, 0, 10, 0, 0, -5, 10, -5));
        send_item(mk(0, 0, 10, 0, 2, 0, 8, 0));
        send_item(mk(0, 0, 10, 0, 8, 0, 2, 0));
        send_item(mk(3, 3, 3, 3, -100, 7, 50, -9));
        send_item(mk(0, 0, 10, 0, 4, 5, 4, -5));
        send_item(mk(0, 0, 10, 0, 0, 1, 1, -2));
        send_item(mk(0, 0, 10, 0, 0, -1, 1, 2));
        send_item(mk(0, 0, 10, 0, 0, 1, 3, -1));
        send_item(mk(0, 0, 10, 0, 0, -1, -3, 1));
        send_item(mk(0, 0, 0, 10, -1, 0, 2, 5));
        send_item(mk(0, 0, 10, 0, 0, 0, 5, 5));
        send_item(mk(0, 0, 10, 0, 0, 0, 5, -5));
        send_item(mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        send_item(mk(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
        send_item(mk(-32768, 0, 32767, 0, -32768, 32767, 32767, -32768));
        send_item(mk(0, -32768, 0, 32767, 32767, -1, -32768, 1));
        send_item(mk(-32768, -32768, -32768, -32768, 32767, 32767, -32768, -32768));
        send_item(mk(-1, -1, -1, -1, 0, 0, 0, 0));
        send_item(mk(1, 2, 3, 5, 7, -4, -9, 11));

        // Random phases with shifting idle rates.
        run_phase(400);
        send_idle_pct = 68; recv_idle_pct = 12;
        run_phase(400);
        send_idle_pct = 0; recv_idle_pct = 0;
        // Long receiver hold-off while the sender keeps offering.
        fork
            begin
                recv_hold = 1;
                repeat (200) @(posedge aclk);
                recv_hold = 0;
            end
            run_phase(100);
        join
        run_phase(400);

        wait_empty();
        sim_done = 1;
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire
